// File: rtl/core/avp_pkg.sv
// Package for the Antoine vapor-pressure block: widths, status codes and the
// constant fraction table of 2^(i/N). No dependencies.
`default_nettype none

package avp_pkg;

   localparam int TABLE_BITS = 6;
   localparam int TABLE_ENTRIES = 1 << TABLE_BITS;

   localparam int QUOT_BITS = 48;
   localparam int DEN_BITS = 25;

   localparam logic [29:0] LOG2_TEN_Q28 = 30'd891723283;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SAT   = 2'd1,
      STATUS_DZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_COEFF_A = 2'd0,
      CSR_COEFF_B = 2'd1,
      CSR_COEFF_C = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic dzero;
   } div_tag_type;

   typedef logic [31:0] exp_table_type [0:TABLE_ENTRIES];

   function automatic logic root_fits(input logic [63:0] r);
      logic [63:0] p;
      logic        ok;
      p  = 64'd1 << 30;
      ok = 1'b1;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         p = (p * r) >> 30;
         if (p > (64'd1 << 31)) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic exp_table_type build_exp_table();
      exp_table_type tab;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [63:0]   mid;
      logic [63:0]   acc;
      lo = 64'd1 << 30;
      hi = 64'd1 << 31;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         if (root_fits(mid)) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      acc = 64'd1 << 30;
      tab[0] = acc[31:0];
      for (int i = 1; i < TABLE_ENTRIES; i++) begin
         acc = (acc * lo) >> 30;
         tab[i] = acc[31:0];
      end
      tab[TABLE_ENTRIES] = 32'h8000_0000;
      return tab;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

// File: rtl/core/avp_div.sv
// Pipelined restoring divider, one quotient bit per stage, for unsigned magnitudes.
// Depends on avp_pkg.
`default_nettype none

module avp_div
   import avp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire div_tag_type            in_tag,
   input  wire logic [QUOT_BITS-1:0]   in_num,
   input  wire logic [DEN_BITS-1:0]    in_den,
   output div_tag_type                 out_tag,
   output logic [QUOT_BITS-1:0]        out_quot
);

   div_tag_type                tag_ff [0:QUOT_BITS-1];
   logic [QUOT_BITS-1:0]       num_ff [0:QUOT_BITS-1];
   logic [DEN_BITS-1:0]        rem_ff [0:QUOT_BITS-1];
   logic [DEN_BITS-1:0]        den_ff [0:QUOT_BITS-1];

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
      div_tag_type            tag_src;
      logic [QUOT_BITS-1:0]   num_src;
      logic [DEN_BITS-1:0]    rem_src;
      logic [DEN_BITS-1:0]    den_src;
      logic [DEN_BITS:0]      trial;
      logic                   ge;
      logic [DEN_BITS:0]      diff;
      logic [DEN_BITS-1:0]    rem_in;
      logic [QUOT_BITS-1:0]   num_in;

      if (k == 0) begin : g_first
         assign tag_src = in_tag;
         assign num_src = in_num;
         assign rem_src = '0;
         assign den_src = in_den;
      end else begin : g_next
         assign tag_src = tag_ff[k-1];
         assign num_src = num_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      always_comb begin
         trial  = {rem_src, num_src[QUOT_BITS-1]};
         ge     = trial >= {1'b0, den_src};
         diff   = trial - {1'b0, den_src};
         rem_in = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         num_in = {num_src[QUOT_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (advance) begin
            tag_ff[k] <= tag_src;
         end
         if (advance) begin
            num_ff[k] <= num_in;
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
         end
      end
   end

   assign out_tag  = tag_ff[QUOT_BITS-1];
   assign out_quot = num_ff[QUOT_BITS-1];

endmodule

`default_nettype wire

// File: rtl/core/antoine_vapor_pressure.sv
// Antoine vapor-pressure pipeline: temperature in, pressure in pascals out.
// Depends on avp_pkg and avp_div.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    temperature (Q.8 K)
//   rsp_      out        rsp_valid/rsp_ready    pressure_pa (Q40.8 Pa), status
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// One item per cycle while the output is not stalled; 48 of the pipeline stages are the divider.
// A stalled output holds the whole pipeline; the input is ready whenever the
// output register is empty or being taken by a transfer.
// Synchronous reset clears valid bits and the coefficient registers.
`default_nettype none

module antoine_vapor_pressure
   import avp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [23:0]   req_temperature,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [47:0]        rsp_pressure_pa,
   output logic [1:0]         rsp_status,
   input  wire logic          csr_write_en,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   logic        advance;

   logic [31:0] coeff_a_ff;
   logic [31:0] coeff_b_ff;
   logic [23:0] coeff_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff <= '0;
         coeff_b_ff <= '0;
         coeff_c_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_COEFF_A: coeff_a_ff <= csr_wdata;
            CSR_COEFF_B: coeff_b_ff <= csr_wdata;
            CSR_COEFF_C: coeff_c_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   assign advance   = rsp_ready | ~rsp_valid;
   assign req_ready = advance;

   // Stage 0: denominator.
   logic                v0_ff;
   logic signed [24:0]  d_ff;
   logic signed [24:0]  d_in;

   assign d_in = {req_temperature[23], req_temperature} + {coeff_c_ff[23], coeff_c_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
      if (advance) begin
         d_ff <= d_in;
      end
   end

   div_tag_type            div_in_tag;
   div_tag_type            div_out_tag;
   logic [31:0]            b_mag;
   logic [24:0]            d_mag;
   logic [QUOT_BITS-1:0]   div_num;
   logic [QUOT_BITS-1:0]   div_quot;

   always_comb begin
      b_mag = coeff_b_ff[31] ? (32'd0 - coeff_b_ff) : coeff_b_ff;
      d_mag = d_ff[24] ? (25'd0 - d_ff) : d_ff;
      div_num = {b_mag, 16'd0};
      div_in_tag.valid = v0_ff;
      div_in_tag.neg   = coeff_b_ff[31] ^ d_ff[24];
      div_in_tag.dzero = (d_ff == 25'sd0);
   end

   avp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_tag   (div_in_tag),
      .in_num   (div_num),
      .in_den   (d_mag),
      .out_tag  (div_out_tag),
      .out_quot (div_quot)
   );

   // Stage X: exponent x5 = A - q + 5, clamped to plus or minus 32.
   localparam logic signed [49:0] X5_HI = 50'sd1 <<< 29;
   localparam logic signed [49:0] X5_LO = -(50'sd1 <<< 29);

   logic                v1_ff;
   logic                z1_ff;
   logic signed [30:0]  x5_ff;
   logic signed [49:0]  q_ext;
   logic signed [49:0]  x5_wide;
   logic signed [30:0]  x5_in;

   always_comb begin
      q_ext = div_out_tag.neg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
      x5_wide = $signed({{18{coeff_a_ff[31]}}, coeff_a_ff}) - q_ext + (50'sd5 <<< 24);
      if (x5_wide > X5_HI) begin
         x5_in = X5_HI[30:0];
      end else if (x5_wide < X5_LO) begin
         x5_in = X5_LO[30:0];
      end else begin
         x5_in = x5_wide[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= div_out_tag.valid;
      end
      if (advance) begin
         z1_ff <= div_out_tag.dzero;
         x5_ff <= x5_in;
      end
   end

   // Stage M: scale by log2(10).
   logic                v2_ff;
   logic                z2_ff;
   logic signed [61:0]  prod_ff;
   logic signed [61:0]  prod_in;

   assign prod_in = x5_ff * $signed({1'b0, LOG2_TEN_Q28});

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         z2_ff <= z1_ff;
         prod_ff <= prod_in;
      end
   end

   // Stage T: table lookup of the fraction.
   logic                        v3_ff;
   logic                        z3_ff;
   logic signed [9:0]           n3_ff;
   logic [31:0]                 t0_ff;
   logic [31:0]                 diff_ff;
   logic [23:0]                 rem_ff;
   logic [23:0]                 frac;
   logic [TABLE_BITS-1:0]       idx;
   logic [23:0]                 rem_in;
   logic [31:0]                 t0_in;
   logic [31:0]                 t1_in;

   always_comb begin
      frac   = prod_ff[51:28];
      idx    = frac[23 -: TABLE_BITS];
      rem_in = {frac[23-TABLE_BITS:0], {TABLE_BITS{1'b0}}};
      t0_in  = EXP_TABLE[{1'b0, idx}];
      t1_in  = EXP_TABLE[{1'b0, idx} + (TABLE_BITS+1)'(1)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         z3_ff   <= z2_ff;
         n3_ff   <= prod_ff[61:52];
         t0_ff   <= t0_in;
         diff_ff <= t1_in - t0_in;
         rem_ff  <= rem_in;
      end
   end

   // Stage I: interpolation product.
   logic                v4_ff;
   logic                z4_ff;
   logic signed [9:0]   n4_ff;
   logic [31:0]         t04_ff;
   logic [55:0]         interp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         z4_ff     <= z3_ff;
         n4_ff     <= n3_ff;
         t04_ff    <= t0_ff;
         interp_ff <= diff_ff * rem_ff;
      end
   end

   // Stage O: mantissa, shift and output register.
   logic                rsp_valid_ff;
   logic [47:0]         pressure_ff;
   status_type          status_ff;
   logic [31:0]         mant;
   logic signed [9:0]   rshift;
   logic signed [9:0]   lshift;
   logic [47:0]         pressure_in;
   status_type          status_in;

   always_comb begin
      mant   = t04_ff + interp_ff[55:24];
      lshift = n4_ff - 10'sd22;
      rshift = 10'sd22 - n4_ff;
      pressure_in = '0;
      status_in   = STATUS_OK;
      if (z4_ff) begin
         status_in = STATUS_DZERO;
      end else if (n4_ff >= 10'sd40) begin
         pressure_in = '1;
         status_in   = STATUS_SAT;
      end else if (n4_ff >= 10'sd22) begin
         pressure_in = {16'd0, mant} << lshift[4:0];
      end else if (rshift < 10'sd32) begin
         pressure_in = {16'd0, mant >> rshift[4:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v4_ff;
      end
      if (advance) begin
         pressure_ff <= pressure_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pressure_pa = pressure_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

// File: bench/avp_checker.sv
// Checker for the Antoine vapor-pressure block: predicts each pressure from the
// accepted temperatures and the coefficient writes, and compares the results.
// Depends on avp_pkg.
module avp_checker
   import avp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [23:0] req_temperature,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [47:0] rsp_pressure_pa,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic [47:0] pressure;
      status_type  status;
   } pressure_result_type;

   logic [63:0] frac_root [0:TABLE_ENTRIES];
   logic signed [63:0] a_coeff, b_coeff, c_coeff;
   pressure_result_type expected_pressures[$];

   function automatic logic root_ok(input logic [63:0] r);
      logic [63:0] p;
      p = 64'd1 << 30;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         p = (p * r) >> 30;
         if (p > (64'd1 << 31)) return 1'b0;
      end
      return 1'b1;
   endfunction

   initial begin
      logic [63:0] lo, hi, mid;
      lo = 64'd1 << 30;
      hi = 64'd1 << 31;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         if (root_ok(mid)) lo = mid;
         else hi = mid - 64'd1;
      end
      frac_root[0] = 64'd1 << 30;
      for (int i = 1; i < TABLE_ENTRIES; i++) frac_root[i] = (frac_root[i-1] * lo) >> 30;
      frac_root[TABLE_ENTRIES] = 64'd1 << 31;
   end

   function automatic pressure_result_type antoine_pressure(input logic [23:0] temp);
      logic signed [63:0] t, d, q, x5, prod, y, n, f, shift;
      logic [63:0] g, idx, rem, t0, t1, m, p;
      pressure_result_type res;
      t = {{40{temp[23]}}, temp};
      d = t + c_coeff;
      if (d == 0) begin
         res.pressure = '0;
         res.status = STATUS_DZERO;
         return res;
      end
      q = (b_coeff * 64'sd65536) / d;
      x5 = a_coeff - q + (64'sd5 <<< 24);
      if (x5 > (64'sd32 <<< 24)) x5 = 64'sd32 <<< 24;
      if (x5 < -(64'sd32 <<< 24)) x5 = -(64'sd32 <<< 24);
      prod = x5 * 64'sd891723283;
      y = prod >>> 28;
      n = y >>> 24;
      f = y - (n <<< 24);
      g = f * TABLE_ENTRIES;
      idx = g >> 24;
      rem = g & 64'hFF_FFFF;
      if (idx >= TABLE_ENTRIES) idx = TABLE_ENTRIES - 1;
      t0 = frac_root[idx];
      t1 = frac_root[idx + 1];
      m = t0 + (((t1 - t0) * rem) >> 24);
      res.status = STATUS_OK;
      if (n + 8 >= 48) begin
         res.pressure = '1;
         res.status = STATUS_SAT;
         return res;
      end
      shift = n - 22;
      if (shift >= 0) p = m << shift;
      else if (shift <= -64) p = 0;
      else p = m >> (-shift);
      if (p > 64'hFFFF_FFFF_FFFF) begin
         res.pressure = '1;
         res.status = STATUS_SAT;
      end else begin
         res.pressure = p[47:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      pressure_result_type exp_res;
      if (reset) begin
         a_coeff <= 0;
         b_coeff <= 0;
         c_coeff <= 0;
         fail_count <= 0;
         expected_pressures.delete();
      end else begin
         if (req_valid && req_ready) expected_pressures.push_back(antoine_pressure(req_temperature));
         if (rsp_valid && rsp_ready) begin
            if (expected_pressures.size() == 0) begin
               $display("%0t: unexpected result pressure %0h status %0d", $time,
                  rsp_pressure_pa, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = expected_pressures.pop_front();
               if (exp_res.pressure !== rsp_pressure_pa || exp_res.status !== rsp_status) begin
                  $display("%0t: expected pressure %0h status %0d, got %0h status %0d",
                     $time, exp_res.pressure, exp_res.status, rsp_pressure_pa, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_COEFF_A: a_coeff <= {{32{csr_wdata[31]}}, csr_wdata};
               CSR_COEFF_B: b_coeff <= {{32{csr_wdata[31]}}, csr_wdata};
               CSR_COEFF_C: c_coeff <= {{40{csr_wdata[23]}}, csr_wdata[23:0]};
               default: ;
            endcase
         end
      end
   end

   assign pending_count = expected_pressures.size();

endmodule

// File: bench/tb.sv
// Testbench top for the Antoine vapor-pressure block: drives temperatures in
// bursts, coefficient sets between phases, and a stalling receiver.
// Depends on avp_pkg, avp_checker and the block itself.
module tb;
   import avp_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [23:0] req_temperature = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [47:0] rsp_pressure_pa;
   logic [1:0]  rsp_status;
   logic        csr_write_en = 0;
   logic [1:0]  csr_index = CSR_COEFF_A;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   logic        hold_off = 0;
   logic [23:0] c_now = '0;

   always #10 clock = ~clock;

   antoine_vapor_pressure dut (.*);
   avp_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off in its own count.
   always @(posedge clock) begin
      if (hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || (cycle_count % 512 < 64);
   end

   initial begin
      repeat (500) @(posedge clock);
      while (!req_valid) @(posedge clock);
      hold_off <= 1;
      repeat (300) @(posedge clock);
      hold_off <= 0;
   end

   task automatic write_coeff(input csr_index_type idx, input logic [31:0] value);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_COEFF_C) c_now = value[23:0];
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   task automatic send_temperature(input logic [23:0] temp);
      req_valid <= 1;
      req_temperature <= temp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [23:0] random_temperature();
      case ($urandom_range(0, 5))
         0: return 24'($urandom());
         1: return -c_now;
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'(256 * $urandom_range(150, 700) + $urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic [31:0] a_set [6] = '{32'd0, 32'h0402_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h0400_0000, $urandom()};
      logic [31:0] b_set [6] = '{32'd0, 32'h04C4_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h0500_0000, $urandom()};
      logic [31:0] c_set [6] = '{32'd0, 32'hFFF0_0000, 32'h007F_FFFF,
                                 32'h0080_0000, 32'hFFFF_C000, $urandom()};
      logic [23:0] directed [12] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001,
                                     24'hFFFFFF, 24'h012C00, 24'h017300, 24'h00FF00,
                                     24'h5A5A5A, 24'hA5A5A5, 24'h040000, 24'h000100};
      int burst;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 12; i++) send_temperature(directed[i]);
      send_temperature(24'h000000);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         write_coeff(CSR_COEFF_A, a_set[phase]);
         write_coeff(CSR_COEFF_B, b_set[phase]);
         write_coeff(CSR_COEFF_C, c_set[phase]);
         send_temperature(-c_now);
         for (int i = 0; i < 140; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++, i++) send_temperature(random_temperature());
            if ($urandom_range(0, 2) == 0) begin
               req_valid <= 0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
